### design/uud_pkg.sv
package uud_pkg;

   typedef enum logic [1:0] {
      PH_LENGTH,
      PH_DATA,
      PH_SKIP,
      PH_STOP
   } phase_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [5:0] SEXTET_MASK = 6'o77;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   // result queue: room for three results per request
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;
   localparam logic [FIFO_CW-1:0] FIFO_DEPTH_C = 4'd8;
   localparam logic [FIFO_CW-1:0] FIFO_LIMIT   = 4'd5;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_out;
      logic [31:0] total_bytes;
      logic        last;
   } result_type;

   function automatic logic is_term(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL);
   endfunction

   function automatic logic [5:0] sextet(input logic [7:0] c);
      logic [7:0] d;
      d = c - CHAR_SPACE;
      return d[5:0] & SEXTET_MASK;
   endfunction

endpackage

### design/uud_if.sv
interface uud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_stream;

   modport source (output valid, output char_in, output end_of_stream, input ready);
   modport sink   (input valid, input char_in, input end_of_stream, output ready);
endinterface

interface uud_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_out;
   logic [31:0] total_bytes;
   logic        last;

   modport source (output valid, output kind, output data_out, output total_bytes,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_out, input total_bytes,
                   input last, output ready);
endinterface

### design/uudecode_stream_core.sv
// Streaming uudecoder core.
// req_chan carries one text byte per request (char_in), or an end-of-stream
// marker (end_of_stream = 1) that asks for the running byte total.
// rsp_chan returns results: kind 0 is a decoded byte, kind 1 the total count;
// last marks the final result caused by one request.
// csr_wr_en/csr_wr_data write discard_data: when set, bytes are counted but
// not returned. Write it only while the block is idle.
// Throughput: one request per cycle while req_chan.ready is high, and one
// result per cycle while the receiver takes them. A four-character group
// gives at most three results, so text streams in without pause while the
// receiver keeps up. Results wait in a registered eight-entry queue; the
// request side stays ready while the queue has room for three more results.
// When the receiver stalls, the queue fills and req_chan.ready drops; nothing
// is lost. Reset (synchronous, active high) empties the queue, clears the
// byte total and returns the decoder to the start of a line.
module uudecode_stream_core (
   input  logic              clock,
   input  logic              reset,
   uud_req_if.sink           req_chan,
   uud_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import uud_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [5:0]             remaining_ff, remaining_in;
   logic [1:0]             group_pos_ff, group_pos_in;
   logic [17:0]            held_ff, held_in;
   logic [31:0]            total_ff, total_in;
   logic                   discard_ff;

   result_type             queue_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]     count_ff, count_in;

   logic                   req_acc, rsp_acc;
   logic [5:0]             sx, sa, sb, sc;
   logic                   term;
   logic [1:0]             nb;
   logic [1:0]             wr_cnt;
   logic [7:0]             bytes [3];
   logic [31:0]            tot [3];
   logic [32:0]            sum [3];
   result_type             wr_entry [3];

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff <= FIFO_LIMIT);

   assign sx   = sextet(req_chan.char_in);
   assign term = is_term(req_chan.char_in);
   assign sa   = held_ff[17:12];
   assign sb   = held_ff[11:6];
   assign sc   = held_ff[5:0];

   assign bytes[0] = {sa, sb[5:4]};
   assign bytes[1] = {sb[3:0], sc[5:2]};
   assign bytes[2] = {sc[1:0], sx};

   // saturating totals after one, two and three more bytes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = {1'b0, total_ff} + 33'(i + 1);
         tot[i] = sum[i][32] ? TOTAL_MAX : sum[i][31:0];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      group_pos_in = group_pos_ff;
      held_in      = held_ff;
      total_in     = total_ff;
      nb           = 2'd0;
      wr_cnt       = 2'd0;
      for (int i = 0; i < 3; i++) begin
         wr_entry[i].kind        = KIND_DATA;
         wr_entry[i].data_out    = bytes[i];
         wr_entry[i].total_bytes = tot[i];
         wr_entry[i].last        = 1'b0;
      end

      if (req_acc) begin
         if (req_chan.end_of_stream) begin
            wr_cnt                  = 2'd1;
            wr_entry[0].kind        = KIND_TOTAL;
            wr_entry[0].data_out    = 8'd0;
            wr_entry[0].total_bytes = total_ff;
            wr_entry[0].last        = 1'b1;
         end else begin
            case (phase_ff)
               PH_LENGTH: begin
                  if (term) begin
                     phase_in = PH_STOP;
                  end else begin
                     remaining_in = sx;
                     group_pos_in = 2'd0;
                     held_in      = 18'd0;
                     phase_in     = (sx != 6'd0) ? PH_DATA : PH_SKIP;
                  end
               end
               PH_DATA: begin
                  if (term) begin
                     phase_in     = (req_chan.char_in == CHAR_LF) ? PH_LENGTH : PH_SKIP;
                     group_pos_in = 2'd0;
                     held_in      = 18'd0;
                  end else if (group_pos_ff != 2'd3) begin
                     held_in      = {held_ff[11:0], sx};
                     group_pos_in = group_pos_ff + 2'd1;
                  end else begin
                     // group complete: up to three bytes while the line count lasts
                     nb           = (remaining_ff >= 6'd3) ? 2'd3 : remaining_ff[1:0];
                     remaining_in = remaining_ff - 6'(nb);
                     if (nb != 2'd0) begin
                        total_in = tot[nb - 2'd1];
                        wr_entry[nb - 2'd1].last = 1'b1;
                     end
                     wr_cnt       = discard_ff ? 2'd0 : nb;
                     group_pos_in = 2'd0;
                     held_in      = 18'd0;
                     if (remaining_in == 6'd0) begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  if (req_chan.char_in == CHAR_LF) begin
                     phase_in = PH_LENGTH;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end

      count_in = count_ff + FIFO_CW'(wr_cnt) - FIFO_CW'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LENGTH;
         remaining_ff <= 6'd0;
         group_pos_ff <= 2'd0;
         held_ff      <= 18'd0;
         total_ff     <= 32'd0;
         discard_ff   <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         group_pos_ff <= group_pos_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         if (csr_wr_en) begin
            discard_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(wr_cnt);
         if (rsp_acc) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < wr_cnt) begin
            queue_mem[wr_ptr_ff + FIFO_AW'(i)] <= wr_entry[i];
         end
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.kind        = queue_mem[rd_ptr_ff].kind;
   assign rsp_chan.data_out    = queue_mem[rd_ptr_ff].data_out;
   assign rsp_chan.total_bytes = queue_mem[rd_ptr_ff].total_bytes;
   assign rsp_chan.last        = queue_mem[rd_ptr_ff].last;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_DEPTH_C)
      else $error("result queue overflow");

   a_eos_result : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.end_of_stream) |=> (count_ff != '0))
      else $error("end of stream request left no result");

   a_stop_sticky : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) |=> (phase_ff == PH_STOP))
      else $error("decoder left stopped phase");

   a_total_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("byte total decreased");

   a_eos_holds_state : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.end_of_stream) |=>
         ($stable(phase_ff) && $stable(remaining_ff) && $stable(total_ff)))
      else $error("end of stream request changed decoder state");

endmodule
